@@ src/nbp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nbp_pkg
// Types and constants shared by the nine-bit word byte packer modules.
// ----------------------------------------------------------------------------
package nbp_pkg;

    localparam logic       FUNC_PUSH   = 1'b0;
    localparam logic       FUNC_FLUSH  = 1'b1;
    localparam logic [2:0] LAST_POS    = 3'd7;
    localparam int         QUEUE_DEPTH = 2;

    typedef struct packed {
        logic       func;
        logic       ctl_bit;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       group_end;
    } t_out_item;

    // Oldest queued request as seen by the packing engine
    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_head;

endpackage

`default_nettype wire

@@ src/nbp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nbp_front
// Request intake: a short queue that decouples the input side from the
// packing engine.
// ----------------------------------------------------------------------------
module nbp_front
    import nbp_pkg::*;
#(
    parameter int Q_DEPTH = QUEUE_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_in_item i_data,
    output logic          o_full,
    output t_head         o_head,
    input  wire logic     i_head_pop
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_in_item             r_mem [Q_DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]     r_count,  n_count;
    logic                 w_wr;
    logic                 w_rd;

    assign o_full        = (r_count == CNT_W'(Q_DEPTH));
    assign o_head.valid  = (r_count != '0);
    assign o_head.item   = r_mem[r_rd_ptr];

    assign w_wr = i_push && !o_full;
    assign w_rd = i_head_pop && o_head.valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ src/nbp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nbp_back
// Packing engine: turns queued words and flushes into bytes, one byte per
// cycle while the output slot is free, into a registered output slot.
// ----------------------------------------------------------------------------
module nbp_back
    import nbp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_head i_head,
    output logic       o_head_pop,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_out_item  o_data
);

    logic [2:0]  r_pos,       n_pos;
    logic [7:0]  r_prev,      n_prev;
    logic        r_tail,      n_tail;
    logic [7:0]  r_tail_data, n_tail_data;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out,       n_out;

    logic        w_slot_free;
    logic        w_load;
    logic [16:0] w_window;
    logic [7:0]  w_byte;
    logic        w_is_flush;

    assign w_slot_free = !r_out_valid || i_pop;
    assign w_is_flush  = (i_head.item.func == FUNC_FLUSH);

    // prev | ctl | data laid out MSB first; the byte at position p begins
    // with the last p bits of the previous word's data
    assign w_window = {r_prev, i_head.item.ctl_bit, i_head.item.data_byte}
                      >> ({1'b0, r_pos} + 4'd1);
    assign w_byte   = w_window[7:0];

    always_comb begin
        n_pos       = r_pos;
        n_prev      = r_prev;
        n_tail      = r_tail;
        n_tail_data = r_tail_data;
        n_out       = r_out;
        w_load      = 1'b0;
        o_head_pop  = 1'b0;
        if (r_tail) begin
            if (w_slot_free) begin
                w_load          = 1'b1;
                n_out.packed_byte = r_tail_data;
                n_out.group_end = 1'b1;
                n_tail          = 1'b0;
                n_pos           = '0;
                n_prev          = '0;
                // a flush that closed the group is done now
                o_head_pop      = i_head.valid && w_is_flush;
            end
        end else if (i_head.valid) begin
            if (w_is_flush && r_pos == '0) begin
                o_head_pop = 1'b1;
            end else if (w_slot_free) begin
                w_load            = 1'b1;
                n_out.packed_byte = w_byte;
                n_out.group_end   = 1'b0;
                o_head_pop        = !w_is_flush;
                if (r_pos == LAST_POS) begin
                    n_tail      = 1'b1;
                    n_tail_data = i_head.item.data_byte;
                end else begin
                    n_pos  = r_pos + 1'b1;
                    n_prev = i_head.item.data_byte;
                end
            end
        end
        n_out_valid = w_load || (r_out_valid && !i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_prev      <= '0;
            r_tail      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_prev      <= n_prev;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tail_data <= n_tail_data;
        r_out       <= n_out;
    end

    assign o_empty = !r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

@@ src/nine_bit_word_byte_packer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nine_bit_word_byte_packer_core
// Packs 9-bit words (control bit + data byte, MSB first) into a byte stream.
//
// Input side is a queue: a request (push word or flush group) is taken when
// push is high and full is low. Output side is a queue too: the oldest byte
// sits on o_data while empty is low and is taken when pop is high.
// A pushed word yields one byte; the eighth word of a group yields two, the
// second flagged group_end. A flush pads the open group with copies of its
// word and yields nothing when no group is open.
// A byte reaches o_data through the request queue and the output register.
// A flush yields one byte per padding word plus the closing byte. The
// engine emits one byte per cycle while the output slot is free or popped;
// the single output register sets that limit, and a Q_DEPTH-entry request
// queue lets requests arrive while the engine works. While pop is low the
// byte holds and the engine stalls; once the queue fills, full rises.
// Reset empties both queues and starts a fresh group.
// ----------------------------------------------------------------------------
module nine_bit_word_byte_packer_core
    import nbp_pkg::*;
#(
    parameter int Q_DEPTH = QUEUE_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    input  wire t_in_item i_data,
    output logic          full,
    output logic          empty,
    input  wire logic     pop,
    output t_out_item     o_data
);

    t_head w_head;
    logic  w_head_pop;

    nbp_front #(
        .Q_DEPTH (Q_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (i_data),
        .o_full     (full),
        .o_head     (w_head),
        .i_head_pop (w_head_pop)
    );

    nbp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .o_head_pop (w_head_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_data     (o_data)
    );

    // a byte that closes a group is never directly followed by another one
    a_no_double_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_data.group_end) |=> (empty || !o_data.group_end))
        else $error("two group_end bytes in a row");

    // the cycle after a request is taken, the engine sees a valid head request
    a_req_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> w_head.valid)
        else $error("accepted request missing from queue");

    // a full queue always presents a head request
    a_full_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> w_head.valid)
        else $error("queue full without a head request");

endmodule

`default_nettype wire
